[src/forest_fire_grid_automaton_unit_defines.svh]
// Assertion macros shared by the checker of the forest fire grid unit.
// Depends on nothing; include by bare file name.
`ifndef FOREST_FIRE_GRID_AUTOMATON_UNIT_DEFINES_SVH
`define FOREST_FIRE_GRID_AUTOMATON_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFGA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ffga check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define FFGA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ffga check failed: next-cycle rule");

`endif

[src/ffga_pkg.sv]
// Shared types and constants of the forest fire grid unit.
// Depends on nothing; used by the sequencer, the top level, both checkers and the testbench.
package ffga_pkg;

	typedef enum logic [1:0] {
		CELL_ROCK    = 2'd0,
		CELL_TREE    = 2'd1,
		CELL_BURNING = 2'd2,
		CELL_BURNT   = 2'd3
	} cell_t;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_UPDATE = 2'd1,
		KIND_COMMIT = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OFF_ZERO  = 2'd0,
		OFF_MINUS = 2'd1,
		OFF_PLUS  = 2'd2
	} off_t;

	typedef struct packed {
		off_t dr;
		off_t dc;
	} offset_t;

	typedef struct packed {
		logic [1:0] cell_state;
		logic [3:0] burning_count;
		logic       out_of_range;
	} result_t;

	// Cell itself first, then the eight Moore neighbors.
	localparam int NEIGHBOR_STEPS = 9;
	localparam logic [3:0] LAST_STEP = 4'(NEIGHBOR_STEPS - 1);

	// Ignition probability 0.2/7 * s + 5.4/7 = (s + 27) / 35, compared exactly
	// against a 16-bit draw: rnd * 35 < (s + 27) * 2^16.
	localparam int IGNITE_BIAS  = 27;
	localparam int IGNITE_SCALE = 35;
	localparam int DRAW_BITS    = 16;
	localparam int PROD_BITS    = 22;

	function automatic offset_t step_offset(logic [3:0] step);
		offset_t o;
		o = '{dr: OFF_ZERO, dc: OFF_ZERO};
		case (step)
			4'd1: o = '{dr: OFF_MINUS, dc: OFF_MINUS};
			4'd2: o = '{dr: OFF_MINUS, dc: OFF_ZERO};
			4'd3: o = '{dr: OFF_MINUS, dc: OFF_PLUS};
			4'd4: o = '{dr: OFF_ZERO,  dc: OFF_MINUS};
			4'd5: o = '{dr: OFF_ZERO,  dc: OFF_PLUS};
			4'd6: o = '{dr: OFF_PLUS,  dc: OFF_MINUS};
			4'd7: o = '{dr: OFF_PLUS,  dc: OFF_ZERO};
			4'd8: o = '{dr: OFF_PLUS,  dc: OFF_PLUS};
			default: o = '{dr: OFF_ZERO, dc: OFF_ZERO};
		endcase
		return o;
	endfunction

endpackage

[src/ffga_if.sv]
// Valid/ready channel interfaces for the input and result items.
// Depends on nothing.
interface ffga_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [5:0]  row;
	logic [5:0]  col;
	logic [1:0]  cell_value;
	logic [15:0] random_value;

	modport source (output valid, kind, row, col, cell_value, random_value, input ready);
	modport sink (input valid, kind, row, col, cell_value, random_value, output ready);
endinterface

interface ffga_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] cell_state;
	logic [3:0] burning_count;
	logic       out_of_range;

	modport source (output valid, cell_state, burning_count, out_of_range, input ready);
	modport sink (input valid, cell_state, burning_count, out_of_range, output ready);
endinterface

[src/ffga_grid_mem.sv]
// Synchronous grid memory, one write and one registered read port.
// Depends on nothing; instantiated twice by the sequencer.
module ffga_grid_mem #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [1:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [1:0]    rdata
);
	logic [1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[src/ffga_seq.sv]
// Item sequencer: accepts items, runs the read-modify-write on both grids.
// Depends on ffga_pkg, ffga_if and ffga_grid_mem.
module ffga_seq #(
	parameter int MAX_SIDE = 64,
	parameter int CW = $clog2(MAX_SIDE),
	parameter int SW = $clog2(MAX_SIDE + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	ffga_in_if.sink           in_ch,
	input  logic [SW-1:0]     side,
	output ffga_pkg::result_t res,
	output logic              res_valid,
	input  logic              res_ready
);
	import ffga_pkg::*;

	localparam int AW = 2 * CW;
	localparam int CMPW = (SW > 7) ? SW : 7;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_LOAD   = 10'b00_0000_0010,
		S_READ   = 10'b00_0000_0100,
		S_RWAIT  = 10'b00_0000_1000,
		S_GATHER = 10'b00_0001_0000,
		S_GLAST  = 10'b00_0010_0000,
		S_DECIDE = 10'b00_0100_0000,
		S_COPY   = 10'b00_1000_0000,
		S_CFLUSH = 10'b01_0000_0000,
		S_RESP   = 10'b10_0000_0000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	cell_t           val_q;
	logic [15:0]     rnd_q;
	logic [3:0]      step_q;
	logic            pend_s1;
	logic [3:0]      step_s1;
	cell_t           center_q;
	logic [3:0]      count_q;
	logic [AW-1:0]   copy_q;
	logic            cp_pend_s1;
	logic [AW-1:0]   cp_addr_s1;
	result_t         res_q;

	logic            accept;
	logic            oor;
	offset_t         off;
	logic [CW-1:0]   nb_row;
	logic [CW-1:0]   nb_col;
	logic [AW-1:0]   center_addr;
	logic [AW-1:0]   nb_addr;
	logic            cur_we;
	logic [AW-1:0]   cur_waddr;
	logic [1:0]      cur_wdata;
	logic            cur_re;
	logic [AW-1:0]   cur_raddr;
	logic [1:0]      cur_rdata;
	logic            nxt_we;
	logic [1:0]      nxt_wdata;
	logic            nxt_re;
	logic [1:0]      nxt_rdata;
	logic [PROD_BITS-1:0] draw_prod;
	logic [PROD_BITS-1:0] threshold;
	logic            ignite;
	cell_t           new_state;

	function automatic logic [CW-1:0] wrap_coord(logic [CW-1:0] v, off_t d, logic [SW-1:0] s);
		logic [SW-1:0] up;
		logic [SW-1:0] lo;
		up = SW'(v) + SW'(1);
		lo = s - SW'(1);
		unique case (d)
			OFF_MINUS: return (v == '0) ? lo[CW-1:0] : v - CW'(1);
			OFF_PLUS:  return (up >= s) ? '0 : up[CW-1:0];
			default:   return v;
		endcase
	endfunction

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept = in_ch.valid && in_ch.ready;
	assign oor = (CMPW'(in_ch.row) >= CMPW'(side)) || (CMPW'(in_ch.col) >= CMPW'(side));

	assign off = step_offset(step_q);
	assign nb_row = wrap_coord(row_q, off.dr, side);
	assign nb_col = wrap_coord(col_q, off.dc, side);
	assign center_addr = {row_q, col_q};
	assign nb_addr = {nb_row, nb_col};

	// Current grid: written by load and the commit copy, read by read and update.
	assign cur_we = (state_q == S_LOAD) || cp_pend_s1;
	assign cur_waddr = cp_pend_s1 ? cp_addr_s1 : center_addr;
	assign cur_wdata = cp_pend_s1 ? nxt_rdata : val_q;
	assign cur_re = (state_q == S_READ) || (state_q == S_GATHER);
	assign cur_raddr = (state_q == S_GATHER) ? nb_addr : center_addr;

	// Next grid: written by load and update, read by the commit copy.
	assign nxt_we = (state_q == S_LOAD) || (state_q == S_DECIDE);
	assign nxt_wdata = (state_q == S_LOAD) ? val_q : new_state;
	assign nxt_re = (state_q == S_COPY);

	ffga_grid_mem #(.AW(AW)) u_cur (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.re    (cur_re),
		.raddr (cur_raddr),
		.rdata (cur_rdata)
	);

	ffga_grid_mem #(.AW(AW)) u_nxt (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (center_addr),
		.wdata (nxt_wdata),
		.re    (nxt_re),
		.raddr (copy_q),
		.rdata (nxt_rdata)
	);

	assign draw_prod = PROD_BITS'(rnd_q) * PROD_BITS'(IGNITE_SCALE);
	assign threshold = (PROD_BITS'(count_q) + PROD_BITS'(IGNITE_BIAS)) << DRAW_BITS;
	assign ignite = (count_q != 4'd0) && (draw_prod < threshold);

	always_comb begin
		case (center_q)
			CELL_ROCK:    new_state = CELL_ROCK;
			CELL_TREE:    new_state = ignite ? CELL_BURNING : CELL_TREE;
			default:      new_state = CELL_BURNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_s1 <= 1'b0;
			cp_pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == S_GATHER);
			cp_pend_s1 <= (state_q == S_COPY);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind_t'(in_ch.kind) == KIND_COMMIT) begin
							state_q <= S_COPY;
						end else if (oor) begin
							state_q <= S_RESP;
						end else begin
							unique case (kind_t'(in_ch.kind))
								KIND_LOAD:   state_q <= S_LOAD;
								KIND_READ:   state_q <= S_READ;
								default:     state_q <= S_GATHER;
							endcase
						end
					end
				end
				S_LOAD:   state_q <= S_RESP;
				S_READ:   state_q <= S_RWAIT;
				S_RWAIT:  state_q <= S_RESP;
				S_GATHER: begin
					if (step_q == LAST_STEP) begin
						state_q <= S_GLAST;
					end
				end
				S_GLAST:  state_q <= S_DECIDE;
				S_DECIDE: state_q <= S_RESP;
				S_COPY: begin
					if (copy_q == '1) begin
						state_q <= S_CFLUSH;
					end
				end
				S_CFLUSH: state_q <= S_RESP;
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		step_s1 <= step_q;
		cp_addr_s1 <= copy_q;
		if (accept) begin
			row_q <= CW'(in_ch.row);
			col_q <= CW'(in_ch.col);
			val_q <= cell_t'(in_ch.cell_value);
			rnd_q <= in_ch.random_value;
			step_q <= 4'd0;
			count_q <= 4'd0;
			copy_q <= '0;
			res_q <= '{cell_state: 2'd0, burning_count: 4'd0,
				out_of_range: oor && (kind_t'(in_ch.kind) != KIND_COMMIT)};
		end
		if (state_q == S_GATHER) begin
			step_q <= step_q + 4'd1;
		end
		if (state_q == S_COPY) begin
			copy_q <= copy_q + AW'(1);
		end
		// Fold in the read issued in the cycle before.
		if (pend_s1) begin
			if (step_s1 == 4'd0) begin
				center_q <= cell_t'(cur_rdata);
			end else if (cell_t'(cur_rdata) == CELL_BURNING) begin
				count_q <= count_q + 4'd1;
			end
		end
		if (state_q == S_LOAD) begin
			res_q.cell_state <= val_q;
		end
		if (state_q == S_RWAIT) begin
			res_q.cell_state <= cur_rdata;
		end
		if (state_q == S_DECIDE) begin
			res_q.cell_state <= new_state;
			res_q.burning_count <= (center_q == CELL_TREE) ? count_q : 4'd0;
		end
	end

	assign res = res_q;
	assign res_valid = (state_q == S_RESP);
endmodule

[src/forest_fire_grid_automaton_unit.sv]
// Top level of the forest fire grid unit: side register, sequencer, result register.
// Depends on ffga_pkg, ffga_if and ffga_seq.
//
// One item is in work at a time; the finished result sits in an output register,
// so the next item is taken while that result waits. A read makes one registered
// read of the current grid; an update fetches the cell and its eight neighbors one
// per cycle through the single read port of the current-grid memory, then the
// ignition compare and the next-grid write follow. A commit sweeps the whole next
// grid into the current grid one cell per cycle. Neither grid is cleared after
// reset: load every cell that will be read or updated first.
module forest_fire_grid_automaton_unit #(
	parameter int MAX_SIDE = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	ffga_in_if.sink    in_ch,
	ffga_out_if.source out_ch,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata
);
	import ffga_pkg::*;

	localparam int CW = $clog2(MAX_SIDE);
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int CMPW = (SW > 7) ? SW : 7;

	logic [6:0]    grid_side_q;
	logic [CMPW-1:0] side_x;
	logic [SW-1:0] side;
	result_t       res;
	logic          res_valid;
	logic          res_ready;
	logic          out_valid_q;
	result_t       out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= 7'd64;
		end else if (cfg_we) begin
			grid_side_q <= cfg_wdata;
		end
	end

	// Clamp the programmed side into the range the grid supports.
	always_comb begin
		side_x = CMPW'(grid_side_q);
		if (side_x < CMPW'(2)) begin
			side_x = CMPW'(2);
		end else if (side_x > CMPW'(MAX_SIDE)) begin
			side_x = CMPW'(MAX_SIDE);
		end
	end
	assign side = side_x[SW-1:0];

	ffga_seq #(.MAX_SIDE(MAX_SIDE), .CW(CW), .SW(SW)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.side      (side),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	assign res_ready = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.cell_state = out_q.cell_state;
	assign out_ch.burning_count = out_q.burning_count;
	assign out_ch.out_of_range = out_q.out_of_range;
endmodule

[src/ffga_checker.sv]
// Port-level checks of the forest fire grid unit, bound to the top level.
// Depends on ffga_pkg and the assertion macro header.
`include "forest_fire_grid_automaton_unit_defines.svh"

module ffga_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] cell_state,
	input logic [3:0] burning_count,
	input logic       out_of_range
);
	import ffga_pkg::*;

	// A stalled result holds its payload.
	`FFGA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({cell_state, burning_count, out_of_range}))

	// A flagged item carries no state and no count.
	`FFGA_ASSERT_IMPLIES(a_oor_clean, clk, arst_n, out_valid && out_of_range, cell_state == CELL_ROCK && burning_count == 4'd0)

	// A count is only reported for an updated tree.
	`FFGA_ASSERT_IMPLIES(a_count_tree, clk, arst_n, out_valid && burning_count != 4'd0, burning_count <= 4'd8 && (cell_state == CELL_TREE || cell_state == CELL_BURNING))

	// Items are worked one at a time: ready drops right after an accept.
	`FFGA_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule

bind forest_fire_grid_automaton_unit ffga_checker u_ffga_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.cell_state    (out_ch.cell_state),
	.burning_count (out_ch.burning_count),
	.out_of_range  (out_ch.out_of_range)
);

[sim/ffga_grid_check.sv]
// Checker of the forest fire grid unit: watches both channels and the side register port.
// Keeps its own copy of both grids, predicts every result and compares it field by field.
// Depends on ffga_pkg and ffga_if.
module ffga_grid_check #(
	parameter int MAX_SIDE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	ffga_in_if          in_mon,
	ffga_out_if         out_mon,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	output int unsigned fail_count,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ffga_pkg::*;

	bit [1:0]    live_grid [MAX_SIDE*MAX_SIDE];
	bit [1:0]    staged_grid [MAX_SIDE*MAX_SIDE];
	logic [6:0]  side_reg;
	result_t     expected_cells[$];
	int unsigned mismatches = 0;

	assign fail_count = mismatches;

	function automatic result_t burn_step(kind_t k, int unsigned r, int unsigned c,
			logic [1:0] v, logic [15:0] rnd);
		result_t     res;
		int unsigned e, idx, hits, nr, nc;
		cell_t       here;
		res = '0;
		e = (side_reg < 2) ? 2 : ((side_reg > MAX_SIDE) ? MAX_SIDE : side_reg);
		if (k == KIND_COMMIT) begin
			live_grid = staged_grid;
			return res;
		end
		if (r >= e || c >= e) begin
			res.out_of_range = 1'b1;
			return res;
		end
		idx = r * MAX_SIDE + c;
		case (k)
			KIND_LOAD: begin
				live_grid[idx] = v;
				staged_grid[idx] = v;
				res.cell_state = v;
			end
			KIND_READ: begin
				res.cell_state = live_grid[idx];
			end
			default: begin
				here = cell_t'(live_grid[idx]);
				hits = 0;
				if (here == CELL_TREE) begin
					// on a side of 2 the same neighbor is counted once per offset
					for (int dr = -1; dr <= 1; dr++) begin
						for (int dc = -1; dc <= 1; dc++) begin
							if (dr != 0 || dc != 0) begin
								nr = (r + e + dr) % e;
								nc = (c + e + dc) % e;
								if (live_grid[nr * MAX_SIDE + nc] == CELL_BURNING)
									hits++;
							end
						end
					end
					res.cell_state = CELL_TREE;
					if (hits > 0 && longint'(rnd) * IGNITE_SCALE <
							(longint'(hits + IGNITE_BIAS) << DRAW_BITS))
						res.cell_state = CELL_BURNING;
					res.burning_count = 4'(hits);
				end else if (here == CELL_BURNING) begin
					res.cell_state = CELL_BURNT;
				end else begin
					res.cell_state = here;
				end
				staged_grid[idx] = res.cell_state;
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			side_reg <= 7'd64;
			expected_cells.delete();
			pending <= 0;
		end else begin
			// results first: an item accepted at this edge cannot have its result yet
			if (out_mon.valid && out_mon.ready) begin
				if (expected_cells.size() == 0) begin
					$error("result item with no item awaiting it");
					mismatches++;
				end else begin
					want = expected_cells.pop_front();
					if (out_mon.cell_state !== want.cell_state) begin
						$error("cell_state: expected %0d, got %0d",
							want.cell_state, out_mon.cell_state);
						mismatches++;
					end
					if (out_mon.burning_count !== want.burning_count) begin
						$error("burning_count: expected %0d, got %0d",
							want.burning_count, out_mon.burning_count);
						mismatches++;
					end
					if (out_mon.out_of_range !== want.out_of_range) begin
						$error("out_of_range: expected %0d, got %0d",
							want.out_of_range, out_mon.out_of_range);
						mismatches++;
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				expected_cells.push_back(burn_step(kind_t'(in_mon.kind), in_mon.row,
					in_mon.col, in_mon.cell_value, in_mon.random_value));
			if (cfg_we)
				side_reg <= cfg_wdata;
			pending <= expected_cells.size();
		end
	end

endmodule

[sim/tb.sv]
// Testbench top of the forest fire grid unit: clock, reset, stimulus, side writes, verdict.
// Instantiates the unit and ffga_grid_check beside it; depends on ffga_pkg and ffga_if.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ffga_pkg::*;

	localparam int SIDE_LIMIT = 64;
	// the slowest correct run stays well under this limit; commits are the longest items
	localparam longint unsigned CYCLE_LIMIT = 2_000_000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;

	ffga_in_if  in_ch ();
	ffga_out_if out_ch ();

	int unsigned     fail_count;
	int unsigned     pending;
	longint unsigned cycle_count = 0;
	bit              calm = 1'b0;
	int unsigned     side_now = SIDE_LIMIT;
	int unsigned     commits_left = 30;
	int unsigned     patch_r, patch_c, patch_w;
	// cells written so far in each grid; only these are ever read by read and update items
	bit              cur_def [SIDE_LIMIT*SIDE_LIMIT];
	bit              nxt_def [SIDE_LIMIT*SIDE_LIMIT];

	forest_fire_grid_automaton_unit #(.MAX_SIDE(SIDE_LIMIT)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	ffga_grid_check #(.MAX_SIDE(SIDE_LIMIT)) grid_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int unsigned idle_len();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(4, 40);
	endfunction

	function automatic int unsigned eff_side(int unsigned v);
		return (v < 2) ? 2 : ((v > SIDE_LIMIT) ? SIDE_LIMIT : v);
	endfunction

	function automatic cell_t pick_cell();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 35) return CELL_TREE;
		if (roll < 70) return CELL_BURNING;
		if (roll < 85) return CELL_ROCK;
		return CELL_BURNT;
	endfunction

	function automatic logic [15:0] draw();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 3) return 16'd0;
		if (roll < 6) return 16'hFFFF;
		if (roll < 9) return 16'd52428;
		if (roll < 12) return 16'd52429;
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic bit hood_ready(int unsigned r, int unsigned c);
		int unsigned e;
		e = side_now;
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++)
				if (!cur_def[((r + e + dr) % e) * SIDE_LIMIT + (c + e + dc) % e])
					return 1'b0;
		return 1'b1;
	endfunction

	// Result side: random stalls, none while calm.
	initial begin
		int unsigned hold;
		out_ch.ready = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0)
				hold--;
			else if (!calm && $urandom_range(0, 99) < 20)
				hold = idle_len();
			out_ch.ready <= (hold == 0);
		end
	end

	task automatic send_item(kind_t k, int unsigned r, int unsigned c, cell_t v,
			logic [15:0] rnd);
		int unsigned gap, idx;
		gap = (calm || $urandom_range(0, 99) < 65) ? 0 : idle_len();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= k;
		in_ch.row <= 6'(r);
		in_ch.col <= 6'(c);
		in_ch.cell_value <= v;
		in_ch.random_value <= rnd;
		do @(posedge clk); while (!in_ch.ready);
		idx = r * SIDE_LIMIT + c;
		if (k == KIND_COMMIT) begin
			cur_def = nxt_def;
		end else if (r < side_now && c < side_now) begin
			if (k == KIND_LOAD) begin
				cur_def[idx] = 1'b1;
				nxt_def[idx] = 1'b1;
			end else if (k == KIND_UPDATE) begin
				nxt_def[idx] = 1'b1;
			end
		end
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_side(int unsigned v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= 7'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		side_now = eff_side(v);
	endtask

	task automatic directed_run();
		// side from reset: one burning neighbor across both wrap edges of cell (0,0)
		send_item(KIND_LOAD, 0, 0, CELL_TREE, 16'hFFFF);
		send_item(KIND_LOAD, 63, 63, CELL_BURNING, 16'd0);
		send_item(KIND_LOAD, 63, 0, CELL_ROCK, 16'd0);
		send_item(KIND_LOAD, 63, 1, CELL_BURNT, 16'd0);
		send_item(KIND_LOAD, 0, 63, CELL_TREE, 16'd0);
		send_item(KIND_LOAD, 0, 1, CELL_ROCK, 16'd0);
		send_item(KIND_LOAD, 1, 63, CELL_ROCK, 16'd0);
		send_item(KIND_LOAD, 1, 0, CELL_BURNT, 16'd0);
		send_item(KIND_LOAD, 1, 1, CELL_ROCK, 16'd0);
		// last draw that ignites with one burning neighbor, then the first that does not
		send_item(KIND_UPDATE, 0, 0, CELL_ROCK, 16'd52428);
		send_item(KIND_UPDATE, 0, 0, CELL_ROCK, 16'd52429);
		send_item(KIND_READ, 63, 63, CELL_ROCK, 16'd0);
		send_item(KIND_COMMIT, 63, 63, CELL_BURNT, 16'hFFFF);
		send_item(KIND_READ, 0, 0, CELL_ROCK, 16'd0);
		send_item(KIND_UPDATE, 0, 0, CELL_ROCK, 16'd0);
		commits_left--;

		// side 2: every offset lands on one of three burning cells, count reaches 8
		write_side(2);
		send_item(KIND_LOAD, 0, 1, CELL_BURNING, 16'd0);
		send_item(KIND_LOAD, 1, 0, CELL_BURNING, 16'd0);
		send_item(KIND_LOAD, 1, 1, CELL_BURNING, 16'd0);
		send_item(KIND_UPDATE, 0, 0, CELL_ROCK, 16'hFFFF);
		send_item(KIND_UPDATE, 1, 1, CELL_ROCK, 16'd0);
		send_item(KIND_READ, 2, 0, CELL_ROCK, 16'd0);
		send_item(KIND_UPDATE, 0, 63, CELL_ROCK, 16'hFFFF);
		send_item(KIND_LOAD, 63, 63, CELL_BURNT, 16'd0);
		send_item(KIND_COMMIT, 0, 0, CELL_ROCK, 16'd0);
		send_item(KIND_UPDATE, 1, 1, CELL_ROCK, 16'd0);
		commits_left--;
	endtask

	task automatic run_phase(int unsigned side_cfg, int unsigned n, bit quiet);
		int unsigned e, r, c, roll, tries;
		kind_t       k;
		write_side(side_cfg);
		e = side_now;
		calm = quiet;
		if (e <= 8) begin
			patch_r = 0;
			patch_c = 0;
			patch_w = e;
		end else begin
			patch_w = 6;
			if ($urandom_range(0, 1)) begin
				patch_r = e - 3;
				patch_c = e - 3;
			end else begin
				patch_r = $urandom_range(0, e - 1);
				patch_c = $urandom_range(0, e - 1);
			end
		end
		for (int i = 0; i < patch_w; i++)
			for (int j = 0; j < patch_w; j++)
				send_item(KIND_LOAD, (patch_r + i) % e, (patch_c + j) % e, pick_cell(), draw());

		for (int unsigned n_done = 0; n_done < n; n_done++) begin
			if (n_done == n / 2)
				wait_drained();
			roll = $urandom_range(0, 99);
			r = (patch_r + $urandom_range(0, patch_w - 1)) % e;
			c = (patch_c + $urandom_range(0, patch_w - 1)) % e;
			if (roll < 8 && e < SIDE_LIMIT) begin
				r = $urandom_range(0, 63);
				c = $urandom_range(0, 63);
				case ($urandom_range(0, 2))
					0: r = $urandom_range(e, 63);
					1: c = $urandom_range(e, 63);
					default: begin
						r = $urandom_range(e, 63);
						c = $urandom_range(e, 63);
					end
				endcase
				case ($urandom_range(0, 2))
					0: k = KIND_LOAD;
					1: k = KIND_UPDATE;
					default: k = KIND_READ;
				endcase
				send_item(k, r, c, pick_cell(), draw());
			end else if (roll >= 8 && roll < 13 && commits_left > 0) begin
				commits_left--;
				send_item(KIND_COMMIT, $urandom_range(0, 63), $urandom_range(0, 63),
					pick_cell(), draw());
			end else if (roll < 35) begin
				send_item(KIND_LOAD, r, c, pick_cell(), draw());
			end else if (roll < 55) begin
				if (cur_def[r * SIDE_LIMIT + c])
					send_item(KIND_READ, r, c, pick_cell(), draw());
				else
					send_item(KIND_LOAD, r, c, pick_cell(), draw());
			end else begin
				tries = 0;
				while (!hood_ready(r, c) && tries < 12) begin
					r = (patch_r + $urandom_range(0, patch_w - 1)) % e;
					c = (patch_c + $urandom_range(0, patch_w - 1)) % e;
					tries++;
				end
				// no cell with a fully written neighborhood: load instead
				if (hood_ready(r, c))
					send_item(KIND_UPDATE, r, c, pick_cell(), draw());
				else
					send_item(KIND_LOAD, r, c, pick_cell(), draw());
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		int unsigned sides [11] = '{0, 5, 127, 3, 1, 16, 64, 7, 100, 2, 8};
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_LOAD;
		in_ch.row = '0;
		in_ch.col = '0;
		in_ch.cell_value = '0;
		in_ch.random_value = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_run();
		foreach (sides[p])
			run_phase(sides[p], 12, (p == 3 || p == 7));

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
